/* rtl/yuv422_to_bgr_convert_macros.svh */
// Assertion macros shared by the checker of the YUV 4:2:2 to BGR converter.
// No dependencies; include by bare file name.
`ifndef YUV422_TO_BGR_CONVERT_MACROS_SVH
`define YUV422_TO_BGR_CONVERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Y2B_ASSERT_NOW(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define Y2B_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/y2b_pkg.sv */
// Shared widths, Q12 coefficients and types for the YUV 4:2:2 to BGR converter.
// No dependencies.
package y2b_pkg;

	localparam int SAMPLE_W = 8;
	localparam int Q_SHIFT  = 12;
	// Chroma product: 8-bit signed offset sample times a 14-bit signed coefficient.
	localparam int TERM_W   = 22;
	// Channel sum in Q12: luma term plus one chroma term, with sign.
	localparam int ACC_W    = 23;

	localparam logic signed [TERM_W-1:0] COEF_RV = 22'sd5614;
	localparam logic signed [TERM_W-1:0] COEF_GV = 22'sd2859;
	localparam logic signed [TERM_W-1:0] COEF_GU = 22'sd1383;
	localparam logic signed [TERM_W-1:0] COEF_BU = 22'sd7096;

	localparam logic [SAMPLE_W-1:0] CHANNEL_MAX = 8'd255;

	// Chroma contributions shared by both pixels of a pair.
	typedef struct packed {
		logic signed [TERM_W-1:0] red;
		logic signed [TERM_W-1:0] green;
		logic signed [TERM_W-1:0] blue;
	} chroma_terms_t;

	// One output pixel, blue in the lowest bits.
	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} bgr_t;

endpackage

/* rtl/y2b_chroma.sv */
// Shared chroma stage: removes the 128 offset and forms the Q12 chroma terms.
// Depends on y2b_pkg.
module y2b_chroma (
	input  logic                          clk,
	input  logic                          en,
	input  logic [y2b_pkg::SAMPLE_W-1:0]  chroma_blue,
	input  logic [y2b_pkg::SAMPLE_W-1:0]  chroma_red,
	output y2b_pkg::chroma_terms_t        terms_s1
);

	logic signed [y2b_pkg::SAMPLE_W-1:0] du;
	logic signed [y2b_pkg::SAMPLE_W-1:0] dv;
	logic signed [y2b_pkg::TERM_W-1:0]   du_ext;
	logic signed [y2b_pkg::TERM_W-1:0]   dv_ext;
	y2b_pkg::chroma_terms_t              terms;

	// Subtracting 128 from an unsigned byte flips its top bit.
	assign du = {~chroma_blue[y2b_pkg::SAMPLE_W-1], chroma_blue[y2b_pkg::SAMPLE_W-2:0]};
	assign dv = {~chroma_red[y2b_pkg::SAMPLE_W-1], chroma_red[y2b_pkg::SAMPLE_W-2:0]};

	assign du_ext = {{(y2b_pkg::TERM_W-y2b_pkg::SAMPLE_W){du[y2b_pkg::SAMPLE_W-1]}}, du};
	assign dv_ext = {{(y2b_pkg::TERM_W-y2b_pkg::SAMPLE_W){dv[y2b_pkg::SAMPLE_W-1]}}, dv};

	always_comb begin
		terms.red   = dv_ext * y2b_pkg::COEF_RV;
		terms.green = dv_ext * y2b_pkg::COEF_GV + du_ext * y2b_pkg::COEF_GU;
		terms.blue  = du_ext * y2b_pkg::COEF_BU;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s1 <= terms;
		end
	end

endmodule

/* rtl/y2b_lane.sv */
// One pixel lane: adds the Q12 luma to the shared chroma terms (the green term is subtracted), floors and clamps.
// Depends on y2b_pkg.
module y2b_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [y2b_pkg::SAMPLE_W-1:0]  luma,
	input  y2b_pkg::chroma_terms_t        terms,
	output y2b_pkg::bgr_t                 pixel_s2
);

	logic signed [y2b_pkg::ACC_W-1:0] base;
	logic signed [y2b_pkg::ACC_W-1:0] acc_red;
	logic signed [y2b_pkg::ACC_W-1:0] acc_green;
	logic signed [y2b_pkg::ACC_W-1:0] acc_blue;
	y2b_pkg::bgr_t                    pixel;

	function automatic logic [y2b_pkg::SAMPLE_W-1:0] clamp_q12(
		input logic signed [y2b_pkg::ACC_W-1:0] acc
	);
		logic [y2b_pkg::SAMPLE_W-1:0] result;
		if (acc[y2b_pkg::ACC_W-1]) begin
			result = '0;
		end else if (|acc[y2b_pkg::ACC_W-2:y2b_pkg::Q_SHIFT+y2b_pkg::SAMPLE_W]) begin
			result = y2b_pkg::CHANNEL_MAX;
		end else begin
			result = acc[y2b_pkg::Q_SHIFT +: y2b_pkg::SAMPLE_W];
		end
		return result;
	endfunction

	assign base = {{(y2b_pkg::ACC_W-y2b_pkg::SAMPLE_W-y2b_pkg::Q_SHIFT){1'b0}},
		luma, {y2b_pkg::Q_SHIFT{1'b0}}};

	assign acc_red   = base + {{(y2b_pkg::ACC_W-y2b_pkg::TERM_W){terms.red[y2b_pkg::TERM_W-1]}},
		terms.red};
	assign acc_green = base - {{(y2b_pkg::ACC_W-y2b_pkg::TERM_W){terms.green[y2b_pkg::TERM_W-1]}},
		terms.green};
	assign acc_blue  = base + {{(y2b_pkg::ACC_W-y2b_pkg::TERM_W){terms.blue[y2b_pkg::TERM_W-1]}},
		terms.blue};

	always_comb begin
		pixel.red   = clamp_q12(acc_red);
		pixel.green = clamp_q12(acc_green);
		pixel.blue  = clamp_q12(acc_blue);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s2 <= pixel;
		end
	end

endmodule

/* rtl/yuv422_to_bgr_convert.sv */
// YUV 4:2:2 pixel pair to BGR converter, top level.
// Depends on y2b_pkg, y2b_chroma and y2b_lane.
//
// Usage:
//   Slave stream s_axis carries one item per horizontal pixel pair: two luma
//   samples and the U and V chroma samples shared by the pair. Master stream
//   m_axis returns one item per pair: the clamped BGR channels of both pixels.
//   Each stream moves an item on a rising edge with tvalid and tready high.
// Pipeline:
//   Stage 1 removes the chroma offset and forms the three Q12 chroma terms
//   once per pair. Stage 2 holds two identical lanes, one per pixel, that add
//   the Q12 luma, floor and clamp to 0..255; the output packs both lanes.
// Flow and throughput:
//   An accepted item is registered in stage 1 and then in stage 2, whose outputs
//   form m_axis. One item is accepted every cycle while m_axis_tready is high; the
//   rate is set by the two-stage pipeline, each stage advancing once per cycle.
// Reset and stall:
//   Reset clears both stage valid flags, so no item is in flight afterwards.
//   When the receiver stalls, the output item holds and the stages fill; once
//   both hold an item, s_axis_tready drops until the receiver takes one.
module yuv422_to_bgr_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] luma_first, [15:8] luma_second, [23:16] chroma_blue, [31:24] chroma_red
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] blue_first, [15:8] green_first, [23:16] red_first,
	// [31:24] blue_second, [39:32] green_second, [47:40] red_second
	output logic [47:0] m_axis_tdata
);

	logic                         valid_s1;
	logic                         valid_s2;
	logic                         advance_s1;
	logic                         advance_s2;
	logic [y2b_pkg::SAMPLE_W-1:0] luma_first_s1;
	logic [y2b_pkg::SAMPLE_W-1:0] luma_second_s1;
	y2b_pkg::chroma_terms_t       terms_s1;
	y2b_pkg::bgr_t                pixel_first_s2;
	y2b_pkg::bgr_t                pixel_second_s2;

	// A stage advances when it is empty or its successor makes room.
	assign advance_s2    = !valid_s2 || m_axis_tready;
	assign advance_s1    = !valid_s1 || advance_s2;
	assign s_axis_tready = advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Hold luma beside the chroma terms so both lanes see the same pair.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			luma_first_s1  <= s_axis_tdata[7:0];
			luma_second_s1 <= s_axis_tdata[15:8];
		end
	end

	y2b_chroma u_chroma (
		.clk         (clk),
		.en          (advance_s1),
		.chroma_blue (s_axis_tdata[23:16]),
		.chroma_red  (s_axis_tdata[31:24]),
		.terms_s1    (terms_s1)
	);

	y2b_lane u_lane_first (
		.clk      (clk),
		.en       (advance_s2),
		.luma     (luma_first_s1),
		.terms    (terms_s1),
		.pixel_s2 (pixel_first_s2)
	);

	y2b_lane u_lane_second (
		.clk      (clk),
		.en       (advance_s2),
		.luma     (luma_second_s1),
		.terms    (terms_s1),
		.pixel_s2 (pixel_second_s2)
	);

	// Merge both lanes into one output item, left pixel in the low half.
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {pixel_second_s2.red, pixel_second_s2.green, pixel_second_s2.blue,
		pixel_first_s2.red, pixel_first_s2.green, pixel_first_s2.blue};

endmodule

/* rtl/y2b_checker.sv */
// Port-level checker for the YUV 4:2:2 to BGR converter, bound to the top level.
// Depends on yuv422_to_bgr_convert_macros.svh.
`include "yuv422_to_bgr_convert_macros.svh"

module y2b_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// A stalled output item holds.
	`Y2B_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")

	// An empty output never back-pressures the input.
	`Y2B_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// A fresh output item comes from an accepted item that passed stage 1 and stage 2.
	`Y2B_ASSERT_NOW(a_no_invented, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "output item without matching input")

	// An accepted item reaches the output when the receiver keeps up.
	`Y2B_ASSERT_NEXT(a_latency, clk, arst_n, s_axis_tvalid && s_axis_tready ##1 m_axis_tready, m_axis_tvalid, "accepted item did not reach output")

endmodule

bind yuv422_to_bgr_convert y2b_checker u_y2b_checker (.*);

/* bench/tb_yuv422_to_bgr_convert.sv */
`timescale 1ns / 1ps
// Self-checking bench for yuv422_to_bgr_convert: drives YUV 4:2:2 pixel pairs on s_axis
// and checks every BGR pair on m_axis against a Q12 fixed-point predictor or a typed-in answer.
// Depends on the yuv422_to_bgr_convert RTL only.
module tb_yuv422_to_bgr_convert;

	localparam int FRAC_BITS    = 12;
	localparam int RV_Q12       = 5614;
	localparam int GV_Q12       = 2859;
	localparam int GU_Q12       = 1383;
	localparam int BU_Q12       = 7096;
	localparam int CHROMA_ZERO  = 128;
	localparam int RANDOM_PAIRS = 1635;
	localparam int HOLD_OFF     = 64;
	localparam int STALL_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0]  luma_first;
		logic [7:0]  luma_second;
		logic [7:0]  chroma_blue;
		logic [7:0]  chroma_red;
		logic        known;
		logic [47:0] bgr;
	} pair_case_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	logic [47:0] expected_bgr [$];
	int          pairs_sent;
	int          results_seen;
	int          mismatches;

	string channel_names [6] = '{"blue_first", "green_first", "red_first",
		"blue_second", "green_second", "red_second"};

	// Extremes and mid-scale first; only the neutral-chroma cases carry a typed-in answer.
	pair_case_t pair_cases [15] = '{
		'{8'd0,   8'd0,   8'd128, 8'd128, 1'b1, 48'h000000_000000},
		'{8'd255, 8'd255, 8'd128, 8'd128, 1'b1, 48'hFFFFFF_FFFFFF},
		'{8'd128, 8'd128, 8'd128, 8'd128, 1'b1, 48'h808080_808080},
		'{8'd0,   8'd255, 8'd128, 8'd128, 1'b1, 48'hFFFFFF_000000},
		'{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 48'h0},
		'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 48'h0},
		'{8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 48'h0},
		'{8'd255, 8'd255, 8'd0,   8'd0,   1'b0, 48'h0},
		'{8'd0,   8'd255, 8'd0,   8'd255, 1'b0, 48'h0},
		'{8'd255, 8'd0,   8'd255, 8'd0,   1'b0, 48'h0},
		'{8'd1,   8'd254, 8'd127, 8'd129, 1'b0, 48'h0},
		'{8'd128, 8'd64,  8'd255, 8'd0,   1'b0, 48'h0},
		'{8'd16,  8'd235, 8'd16,  8'd240, 1'b0, 48'h0},
		'{8'hAA,  8'h55,  8'hAA,  8'h55,  1'b0, 48'h0},
		'{8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, 48'h0}
	};

	yuv422_to_bgr_convert DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor by arithmetic shift, then clamp to 0..255.
	function automatic logic [7:0] clamp_channel(input int sum_q12);
		int whole;
		whole = sum_q12 >>> FRAC_BITS;
		if (sum_q12 < 0)
			return 8'd0;
		if (whole > 255)
			return 8'd255;
		return whole[7:0];
	endfunction

	// One pixel, red in the top byte and blue in the bottom byte.
	function automatic logic [23:0] pixel_to_bgr(input logic [7:0] luma, input int du,
			input int dv);
		int base_q12;
		base_q12 = int'(luma) << FRAC_BITS;
		return {clamp_channel(base_q12 + RV_Q12 * dv),
			clamp_channel(base_q12 - GV_Q12 * dv - GU_Q12 * du),
			clamp_channel(base_q12 + BU_Q12 * du)};
	endfunction

	function automatic logic [47:0] pair_to_bgr(input logic [31:0] pair);
		int du;
		int dv;
		du = int'(pair[23:16]) - CHROMA_ZERO;
		dv = int'(pair[31:24]) - CHROMA_ZERO;
		return {pixel_to_bgr(pair[15:8], du, dv), pixel_to_bgr(pair[7:0], du, dv)};
	endfunction

	// Mostly uniform, with a bias towards the clamp and offset boundaries.
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(127 + $urandom_range(0, 1));
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what);
		$display("result %0d: %s", results_seen, what);
		mismatches++;
	endtask

	// Offer one pair, hold it until taken, then idle for a random gap, none in the first 120 of every 400 pairs.
	task automatic send_pair(input logic [31:0] pair, input logic [47:0] want);
		int gap;
		s_axis_tdata  <= pair;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_bgr.push_back(want);
		pairs_sent++;
		gap = ((pairs_sent % 400) < 120) ? 0 : idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender: reset, directed table, random pairs, drain.
	initial begin
		logic [31:0] pair;
		pairs_sent = 0;
		mismatches = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pair_cases[i]) begin
			pair = {pair_cases[i].chroma_red, pair_cases[i].chroma_blue,
				pair_cases[i].luma_second, pair_cases[i].luma_first};
			send_pair(pair, pair_cases[i].known ? pair_cases[i].bgr : pair_to_bgr(pair));
		end

		repeat (RANDOM_PAIRS) begin
			pair = {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
			send_pair(pair, pair_to_bgr(pair));
		end
		s_axis_tvalid <= 1'b0;

		while (expected_bgr.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: check each taken item, stall at random, and hold off once for a long
	// stretch so the pipeline fills and back-pressures the input.
	initial begin
		int          stall_left;
		bit          held_off;
		logic [47:0] got;
		logic [47:0] want;
		stall_left   = 0;
		held_off     = 1'b0;
		results_seen = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_bgr.size() == 0) begin
					report_mismatch($sformatf("unexpected item %h", got));
				end else begin
					want = expected_bgr.pop_front();
					for (int k = 0; k < 6; k++)
						if (got[k*8 +: 8] !== want[k*8 +: 8])
							report_mismatch($sformatf("%s got %0d want %0d",
								channel_names[k], got[k*8 +: 8], want[k*8 +: 8]));
				end
				results_seen++;
			end
			if (!held_off && results_seen >= 40) begin
				stall_left = HOLD_OFF;
				held_off   = 1'b1;
			end else if (stall_left == 0 && (results_seen % 400) < 200
					&& $urandom_range(0, 3) == 0) begin
				stall_left = idle_cycles();
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule
